[sv/arp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_pkg
// Shared types, codes and constants of the ARP cache / next-hop block.
// ============================================================================
package arp_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;   // four 64-bit registers at 8-byte strides

    localparam logic [MAC_W-1:0] BROADCAST_MAC    = 48'hFFFF_FFFF_FFFF;
    localparam logic [MAC_W-1:0] FALLBACK_MAC_RST = 48'h5255_0A00_0202;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_ROUTE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_OWN_IP       = 2'd0,
        REG_SUBNET_MASK  = 2'd1,
        REG_GATEWAY_IP   = 2'd2,
        REG_FALLBACK_MAC = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [IP_W-1:0]  own_ip;
        logic [IP_W-1:0]  subnet_mask;
        logic [IP_W-1:0]  gateway_ip;
        logic [MAC_W-1:0] fallback_mac;
    } cfg_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac_out;
        logic             on_subnet;
        logic [IP_W-1:0]  next_hop_ip;
    } result_t;

    // Result word for any opcode, given the outcome of the table search.
    function automatic result_t build_result(
        input op_t              op,
        input logic             found,
        input logic [MAC_W-1:0] found_mac,
        input logic             is_local,
        input logic [IP_W-1:0]  hop,
        input logic [MAC_W-1:0] fallback
    );
        result_t r;
        r = '0;
        case (op)
            OP_LOOKUP:
            begin
                r.hit     = found;
                r.mac_out = found ? found_mac : '0;
            end
            OP_ROUTE:
            begin
                r.hit         = found;
                r.on_subnet   = is_local;
                r.next_hop_ip = hop;
                if (found)
                    r.mac_out = found_mac;
                else
                    r.mac_out = is_local ? BROADCAST_MAC : fallback;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

[sv/arp_cache_next_hop.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_cache_next_hop
// IPv4 to MAC address cache with next-hop selection and an APB config port.
// ============================================================================
// Each word is handled on its own. Clear and add pass from acceptance
// through the done state into the output register, and the next word is
// taken once the result has left the done state. Lookup and route scan the
// table through its single read port, one entry per cycle: from entry 0 up
// to the first matching entry, or on a miss up to the last filled entry.
// The result then passes through the done state into the output register,
// and the next word is taken after that. The next word is accepted even
// while that result is still stalled; a later result waits only while the
// output register stays stalled.
// Entries fill from index 0 upward; a full table overwrites entry 0.
module arp_cache_next_hop
    import arp_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [IP_W-1:0]   query_ip,
    input  logic [MAC_W-1:0]  new_mac,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [MAC_W-1:0]  mac_out,
    output logic              on_subnet,
    output logic [IP_W-1:0]   next_hop_ip
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    cfg_t             cfg;
    result_t          out_res;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    arp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arp_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    arp_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .query_ip    (query_ip),
        .new_mac     (new_mac),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_res     (out_res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    assign hit         = out_res.hit;
    assign mac_out     = out_res.mac_out;
    assign on_subnet   = out_res.on_subnet;
    assign next_hop_ip = out_res.next_hop_ip;

endmodule

[sv/arp_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_regs
// APB register file: own address, netmask, gateway and fallback MAC.
// ============================================================================
module arp_regs
    import arp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_OWN_IP:       cfg_next.own_ip       = pwdata[IP_W-1:0];
                REG_SUBNET_MASK:  cfg_next.subnet_mask  = pwdata[IP_W-1:0];
                REG_GATEWAY_IP:   cfg_next.gateway_ip   = pwdata[IP_W-1:0];
                REG_FALLBACK_MAC: cfg_next.fallback_mac = pwdata[MAC_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip       <= '0;
            cfg_reg.subnet_mask  <= '0;
            cfg_reg.gateway_ip   <= '0;
            cfg_reg.fallback_mac <= FALLBACK_MAC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OWN_IP:       prdata = DATA_W'(cfg_reg.own_ip);
            REG_SUBNET_MASK:  prdata = DATA_W'(cfg_reg.subnet_mask);
            REG_GATEWAY_IP:   prdata = DATA_W'(cfg_reg.gateway_ip);
            REG_FALLBACK_MAC: prdata = DATA_W'(cfg_reg.fallback_mac);
            default:          prdata = '0;
        endcase
    end

endmodule

[sv/arp_table.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_table
// Entry store: one write port, one read port, registered read data.
// ============================================================================
module arp_table
    import arp_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/arp_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_ctrl
// Sequencer: fill count, add placement, linear table scan, output word.
// ============================================================================
module arp_ctrl
    import arp_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [IP_W-1:0]   query_ip,
    input  logic [MAC_W-1:0]  new_mac,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           out_res,
    output logic              mem_wr_en,
    output logic [IDX_W-1:0]  mem_wr_addr,
    output entry_t            mem_wr_data,
    output logic              mem_rd_en,
    output logic [IDX_W-1:0]  mem_rd_addr,
    input  entry_t            mem_rd_data
);

    // Entries always fill from index 0 upward and clear resets the fill count,
    // so the valid entries are exactly indexes below the fill count.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    op_t              op_reg, op_next;
    logic             local_reg, local_next;
    logic [IP_W-1:0]  target_reg, target_next;
    result_t          res_reg, res_next;
    result_t          out_res_reg, out_res_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    logic             full;
    logic             in_local;
    op_t              in_op;
    logic             scan_last;
    logic [IDX_W-1:0] scan_idx_inc;

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign in_op        = op_t'(opcode);
    assign full         = (count_reg == CNT_W'(ENTRIES));
    assign in_local     = ((query_ip ^ cfg.own_ip) & cfg.subnet_mask) == '0;
    assign scan_last    = (CNT_W'(scan_idx_reg) == (count_reg - 1'b1));
    assign scan_idx_inc = scan_idx_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        op_next        = op_reg;
        local_next     = local_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = full ? '0 : count_reg[IDX_W-1:0];
        mem_wr_data.ip  = query_ip;
        mem_wr_data.mac = new_mac;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    local_next  = (in_op == OP_ROUTE) && in_local;
                    target_next = (in_op == OP_ROUTE && !in_local) ? cfg.gateway_ip
                                                                    : query_ip;
                    res_next    = '0;
                    state_next  = S_DONE;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_ADD:
                        begin
                            mem_wr_en = 1'b1;
                            if (!full)
                                count_next = count_reg + 1'b1;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = build_result(in_op, 1'b0, '0, local_next,
                                                        target_next, cfg.fallback_mac);
                            end
                            else
                            begin
                                mem_rd_en     = 1'b1;
                                mem_rd_addr   = '0;
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read data here belongs to scan_idx_reg
                if (mem_rd_data.ip == target_reg)
                begin
                    res_next   = build_result(op_reg, 1'b1, mem_rd_data.mac, local_reg,
                                              target_reg, cfg.fallback_mac);
                    state_next = S_DONE;
                end
                else if (scan_last)
                begin
                    res_next   = build_result(op_reg, 1'b0, '0, local_reg,
                                              target_reg, cfg.fallback_mac);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_idx_inc;
                    scan_idx_next = scan_idx_inc;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        op_reg       <= op_next;
        local_reg    <= local_next;
        target_reg   <= target_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count above table depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the table");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_ADD && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add into free slot did not grow fill count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("scan index beyond valid entries");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished result not moved to output");
`endif

endmodule
